### rtl/core/min_max_normalizer_core_defines.svh
// ----------------------------------------------------------------------------
// min_max_normalizer_core_defines.svh
// Assertion macros shared by the normalizer RTL. Empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_NORMALIZER_CORE_DEFINES_SVH
`define MIN_MAX_NORMALIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define MMN_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("normalizer same-cycle check failed");

// next-cycle implication, checked outside reset
`define MMN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("normalizer next-cycle check failed");

`else

`define MMN_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MMN_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/mmn_pkg.sv
// ----------------------------------------------------------------------------
// mmn_pkg
// Types, widths and constants shared by the min-max normalizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mmn_pkg;

   // buffer geometry
   localparam int DEPTH  = 64;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // datapath widths
   localparam int SAMPLE_W = 32;
   localparam int NORM_W   = 17;
   localparam int QUO_W    = NORM_W;
   localparam int DEN_W    = SAMPLE_W + 1;
   localparam int NUM_W    = DEN_W + QUO_W;
   localparam int STEP_W   = $clog2(QUO_W + 1);

   // fixed-point constants
   localparam logic [NORM_W-1:0] ONE_Q16  = 17'h10000;
   localparam logic [NORM_W-1:0] HALF_Q16 = 17'h08000;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_INVERT_IDX = '0;

   // input word
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_value;
      logic                       sample_missing;
      logic                       sample_last;
   } req_type;

   // result word
   typedef struct packed {
      logic [NORM_W-1:0] norm_value;
      logic              norm_missing;
      logic              norm_last;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic start;
      logic read;
      logic diff;
      logic div_start;
      logic result_load;
      logic advance;
      logic clear;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic skip;
      logic at_last;
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/core/mmn_divider.sv
// ----------------------------------------------------------------------------
// mmn_divider
// Restoring divider, one quotient bit per cycle, QUO_W quotient bits per division.
// ----------------------------------------------------------------------------
`default_nettype none
`include "min_max_normalizer_core_defines.svh"

module mmn_divider
   import mmn_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic      [QUO_W-1:0] quotient,
   output logic                  done
);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  low_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] trial_sub;
   logic           take;

   // one trial subtraction
   always_comb begin
      trial     = {rem_ff, low_ff[QUO_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      take      = (trial >= {1'b0, den_ff});
      rem_in    = take ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   // control: busy flag, step count, done flag
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(QUO_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // operands; upper dividend bits start below the divisor
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[NUM_W-1:QUO_W];
         low_ff <= dividend[QUO_W-1:0];
         den_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[QUO_W-2:0], 1'b0};
         quo_ff <= {quo_ff[QUO_W-2:0], take};
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

   `MMN_ASSERT_NEXT(a_start_clears_done, clock, reset, start, !done_ff && busy_ff)

endmodule

`default_nettype wire

### rtl/core/mmn_datapath.sv
// ----------------------------------------------------------------------------
// mmn_datapath
// Sample buffer, running statistics, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "min_max_normalizer_core_defines.svh"

module mmn_datapath
   import mmn_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   input  wire req_type       req_word,
   input  wire logic          invert,
   output dp_status_type      status,
   output rsp_type            rsp_word
);

   // buffer memories
   logic [SAMPLE_W-1:0] sample_mem [DEPTH];
   logic                missing_mem [DEPTH];

   logic [CNT_W-1:0]           stored_cnt_ff;
   logic [CNT_W-1:0]           present_cnt_ff;
   logic signed [SAMPLE_W-1:0] min_ff;
   logic signed [SAMPLE_W-1:0] max_ff;
   logic [ADDR_W-1:0]          idx_ff;
   logic [SAMPLE_W-1:0]        range_ff;
   logic                       flat_ff;
   logic [SAMPLE_W-1:0]        rd_value_ff;
   logic                       rd_missing_ff;
   logic [SAMPLE_W-1:0]        diff_ff;
   rsp_type                    rsp_ff, rsp_in;

   logic              full;
   logic              store_en;
   logic              at_last;
   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic [QUO_W-1:0]  div_quo;
   logic              div_done;
   logic [NORM_W-1:0] quo_sat;

   assign full     = (stored_cnt_ff == CNT_W'(DEPTH));
   assign store_en = cmd.load && !full;
   assign at_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == stored_cnt_ff);

   // buffer write
   always_ff @(posedge clock) begin
      if (store_en) begin
         sample_mem[stored_cnt_ff[ADDR_W-1:0]]  <= req_word.sample_value;
         missing_mem[stored_cnt_ff[ADDR_W-1:0]] <= req_word.sample_missing;
      end
   end

   // buffer read, registered
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_value_ff   <= sample_mem[idx_ff];
         rd_missing_ff <= missing_mem[idx_ff];
      end
   end

   // running statistics
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         stored_cnt_ff  <= '0;
         present_cnt_ff <= '0;
         min_ff         <= SAMPLE_MAX;
         max_ff         <= SAMPLE_MIN;
      end else if (store_en) begin
         stored_cnt_ff <= stored_cnt_ff + CNT_W'(1);
         if (!req_word.sample_missing) begin
            present_cnt_ff <= present_cnt_ff + CNT_W'(1);
            if (req_word.sample_value < min_ff) min_ff <= req_word.sample_value;
            if (req_word.sample_value > max_ff) max_ff <= req_word.sample_value;
         end
      end
   end

   // emission index
   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         idx_ff <= '0;
      end else if (cmd.advance) begin
         idx_ff <= idx_ff + ADDR_W'(1);
      end
   end

   // range and flat flag, fixed for one emission pass
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         range_ff <= max_ff - min_ff;
         flat_ff  <= (present_cnt_ff < CNT_W'(2)) || (max_ff == min_ff);
      end
   end

   // offset from minimum
   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         diff_ff <= rd_value_ff - min_ff;
      end
   end

   // rounded quotient: (2*d*2^16 + range) / (2*range)
   assign div_num = NUM_W'({diff_ff, {QUO_W{1'b0}}}) + NUM_W'(range_ff);
   assign div_den = {range_ff, 1'b0};

   mmn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quo),
      .done     (div_done)
   );

   // result selection
   always_comb begin
      quo_sat = (div_quo > ONE_Q16) ? ONE_Q16 : div_quo;
      rsp_in.norm_last = at_last;
      if (flat_ff) begin
         rsp_in.norm_value   = HALF_Q16;
         rsp_in.norm_missing = 1'b0;
      end else if (rd_missing_ff) begin
         rsp_in.norm_value   = '0;
         rsp_in.norm_missing = 1'b1;
      end else begin
         rsp_in.norm_value   = invert ? (ONE_Q16 - quo_sat) : quo_sat;
         rsp_in.norm_missing = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word        = rsp_ff;
   assign status.skip     = flat_ff || rd_missing_ff;
   assign status.at_last  = at_last;
   assign status.div_done = div_done;

   `MMN_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, stored_cnt_ff <= CNT_W'(DEPTH))
   `MMN_ASSERT_IMPL(a_present_le_stored, clock, reset, 1'b1, present_cnt_ff <= stored_cnt_ff)

endmodule

`default_nettype wire

### rtl/core/mmn_ctrl.sv
// ----------------------------------------------------------------------------
// mmn_ctrl
// Sequencer: loading, per-result read / divide / deliver steps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "min_max_normalizer_core_defines.svh"

module mmn_ctrl
   import mmn_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_last,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output logic               req_ready,
   output logic               rsp_valid,
   output ctrl_cmd_type       cmd
);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_DIFF  = 3'd3;
   localparam logic [2:0] S_DIVGO = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            if (status.skip) begin
               cmd.result_load = 1'b1;
               state_in        = S_OUT;
            end else begin
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.result_load = 1'b1;
               state_in        = S_OUT;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.at_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_LOAD;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   `MMN_ASSERT_IMPL(a_sides_exclusive, clock, reset, 1'b1, !(req_ready && rsp_valid))
   `MMN_ASSERT_NEXT(a_last_word_reloads, clock, reset, rsp_valid && rsp_ready && status.at_last, req_ready)

endmodule

`default_nettype wire

### rtl/core/min_max_normalizer_core.sv
// ----------------------------------------------------------------------------
// min_max_normalizer_core
// Min-max normalization of a vector of signed Q16.16 samples to Q1.16.
// ----------------------------------------------------------------------------
// Samples load one word per cycle into a 64-entry buffer while the minimum,
// maximum and present count are tracked; words past the buffer depth are
// dropped. The word marked last starts emission: a setup step, then one
// result per stored sample, in order. A result that needs a division goes
// through read, offset, divider load, the shared restoring divider at one
// quotient bit per cycle, result load and delivery; a missing sample, or
// any sample of a vector with fewer than two present or all-equal samples,
// goes through read, result load and delivery. Delivery waits while the
// result side stalls. New samples are accepted again the cycle after the
// final result is taken.
// Register 0 (byte address 0, bit 0) sets invert: results become 1.0 minus
// the normalized value. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_normalizer_core
   import mmn_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // sample side
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   // result side
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   // register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic          invert_ff;
   logic          reg_hit;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // register decode
   assign reg_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_INVERT_IDX);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? {{(CSR_DATA_W-1){1'b0}}, invert_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit) begin
         invert_ff <= csr_pwdata[0];
      end
   end

   mmn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.sample_last),
      .rsp_ready (rsp_ready),
      .status    (status),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   mmn_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_data),
      .invert   (invert_ff),
      .status   (status),
      .rsp_word (rsp_data)
   );

endmodule

`default_nettype wire
